>>> design/erwu_pkg.sv
`timescale 1ns / 1ps

package erwu_pkg;

  // queue depths
  localparam int unsigned FRONT_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 2;

  // result kinds
  localparam logic [3:0] KIND_NONE      = 4'd0;
  localparam logic [3:0] KIND_HEAD      = 4'd1;
  localparam logic [3:0] KIND_NIM       = 4'd2;
  localparam logic [3:0] KIND_ADC       = 4'd3;
  localparam logic [3:0] KIND_SCALER    = 4'd4;
  localparam logic [3:0] KIND_TIME      = 4'd5;
  localparam logic [3:0] KIND_V830      = 4'd6;
  localparam logic [3:0] KIND_FERA_HEAD = 4'd7;
  localparam logic [3:0] KIND_FERA_DATA = 4'd8;
  localparam logic [3:0] KIND_CHECKSUM  = 4'd9;
  localparam logic [3:0] KIND_UNKNOWN   = 4'd10;

  // region ids
  localparam logic [3:0] REG_RESERVED = 4'd0;
  localparam logic [3:0] REG_V1190    = 4'd1;
  localparam logic [3:0] REG_NIM      = 4'd2;
  localparam logic [3:0] REG_ADC      = 4'd3;
  localparam logic [3:0] REG_SCALER   = 4'd6;
  localparam logic [3:0] REG_TIME     = 4'd8;
  localparam logic [3:0] REG_V830     = 4'd9;
  localparam logic [3:0] REG_FERA_A   = 4'd13;
  localparam logic [3:0] REG_FERA_B   = 4'd14;
  localparam logic [3:0] REG_CHECKSUM = 4'd15;

  // fera header types
  localparam logic [3:0] FTYPE_GR_ADC  = 4'd0;
  localparam logic [3:0] FTYPE_LAS_ADC = 4'd1;
  localparam logic [3:0] FTYPE_GR_TDC  = 4'd8;
  localparam logic [3:0] FTYPE_LAS_TDC = 4'd9;

  // store targets
  localparam logic [2:0] TGT_GR_ADC  = 3'd0;
  localparam logic [2:0] TGT_LAS_ADC = 3'd1;
  localparam logic [2:0] TGT_GR_TDC  = 3'd2;
  localparam logic [2:0] TGT_LAS_TDC = 3'd3;
  localparam logic [2:0] TGT_NONE    = 3'd4;

  // predecoded word, front to back
  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic [3:0]  hdr_id;
    logic [11:0] hdr_size;
    logic        size_zero;
    logic        fera_hdr;
    logic [3:0]  fera_kind;
    logic [3:0]  fera_module;
    logic [2:0]  fera_chan;
    logic [10:0] fera_data;
  } item_t;

  // one result word
  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  region_id;
    logic [31:0] value;
    logic [7:0]  store_index;
    logic [2:0]  store_target;
    logic [3:0]  fera_kind;
    logic [3:0]  fera_module;
    logic        gr_bit;
    logic        las_bit;
    logic        coin_bit;
    logic        event_end;
    logic        region_cut;
  } res_t;

  function automatic logic [2:0] target_of(input logic [3:0] ftype);
    logic [2:0] t;
    unique case (ftype)
      FTYPE_GR_ADC:  t = TGT_GR_ADC;
      FTYPE_LAS_ADC: t = TGT_LAS_ADC;
      FTYPE_GR_TDC:  t = TGT_GR_TDC;
      FTYPE_LAS_TDC: t = TGT_LAS_TDC;
      default:       t = TGT_NONE;
    endcase
    return t;
  endfunction

endpackage

>>> design/erwu_fifo.sv
`timescale 1ns / 1ps

// small register fifo, DEPTH >= 2
module erwu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> design/erwu_front.sv
`timescale 1ns / 1ps

// accepts raw words, splits out header and fera fields, queues them
module erwu_front #(
  parameter int unsigned DEPTH = erwu_pkg::FRONT_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [15:0]         in_word,
  input  logic                in_last_of_event,
  output logic                full,
  output erwu_pkg::item_t     item,
  output logic                item_valid,
  input  logic                item_take
);

  erwu_pkg::item_t pre;
  logic [$bits(erwu_pkg::item_t)-1:0] q_out;
  logic q_empty;

  always_comb begin
    pre.word        = in_word;
    pre.last        = in_last_of_event;
    pre.hdr_id      = in_word[15:12];
    pre.hdr_size    = in_word[11:0];
    pre.size_zero   = (in_word[11:0] == 12'd0);
    pre.fera_hdr    = in_word[15];
    pre.fera_kind   = in_word[7:4];
    pre.fera_module = in_word[3:0];
    pre.fera_chan   = in_word[14:12];
    pre.fera_data   = in_word[10:0];
  end

  erwu_fifo #(
    .WIDTH ($bits(erwu_pkg::item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (pre),
    .full    (full),
    .rd_en   (item_take),
    .rd_data (q_out),
    .empty   (q_empty)
  );

  assign item       = erwu_pkg::item_t'(q_out);
  assign item_valid = !q_empty;

endmodule

>>> design/erwu_back.sv
`timescale 1ns / 1ps

// region decoder: holds the per-event state and forms at most one result per word
module erwu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_big_endian_order,
  input  erwu_pkg::item_t     item,
  input  logic                item_valid,
  output logic                item_take,
  input  logic                res_full,
  output logic                res_valid,
  output erwu_pkg::res_t      res
);

  logic        big_endian_r;
  logic        in_region_r, in_region_nxt;
  logic [3:0]  cur_region_r, cur_region_nxt;
  logic [11:0] words_left_r, words_left_nxt;
  logic        fera_seen_r, fera_seen_nxt;
  logic [3:0]  fera_type_r, fera_type_nxt;
  logic [3:0]  fera_module_r, fera_module_nxt;
  logic [15:0] held_half_r, held_half_nxt;
  logic        half_pending_r, half_pending_nxt;
  logic        nim_seen_r, nim_seen_nxt;
  logic        ev_gr_r, ev_gr_nxt;
  logic        ev_las_r, ev_las_nxt;
  logic        ev_coin_r, ev_coin_nxt;
  logic        first_done_r, first_done_nxt;

  logic [11:0] wl_dec;
  logic        closing;
  logic        have;
  logic        pair_take;
  logic        pair_ready;
  logic        joined;
  logic [15:0] half_first, half_second;
  logic [31:0] join_low_first, join_high_first;
  logic [3:0]  kind;
  logic [3:0]  rid;
  logic [31:0] value;
  logic [7:0]  idx;
  logic [2:0]  target;

  assign item_take = item_valid && !res_full;
  assign wl_dec    = words_left_r - 12'd1;
  assign closing   = (wl_dec == 12'd0);

  // pair joiner: a lone closing half is joined with zero
  assign half_first      = half_pending_r ? held_half_r : item.word;
  assign half_second     = half_pending_r ? item.word : 16'd0;
  assign join_low_first  = {half_second, half_first};
  assign join_high_first = {half_first, half_second};
  assign pair_ready      = half_pending_r || closing;

  always_comb begin
    in_region_nxt    = in_region_r;
    cur_region_nxt   = cur_region_r;
    words_left_nxt   = words_left_r;
    fera_seen_nxt    = fera_seen_r;
    fera_type_nxt    = fera_type_r;
    fera_module_nxt  = fera_module_r;
    held_half_nxt    = held_half_r;
    half_pending_nxt = half_pending_r;
    nim_seen_nxt     = nim_seen_r;
    ev_gr_nxt        = ev_gr_r;
    ev_las_nxt       = ev_las_r;
    ev_coin_nxt      = ev_coin_r;
    first_done_nxt   = first_done_r;
    have             = 1'b0;
    kind             = erwu_pkg::KIND_NONE;
    rid              = 4'd0;
    value            = 32'd0;
    idx              = 8'd0;
    target           = erwu_pkg::TGT_NONE;
    pair_take        = 1'b0;
    joined           = 1'b0;

    if (!in_region_r) begin
      have  = 1'b1;
      kind  = erwu_pkg::KIND_HEAD;
      rid   = item.hdr_id;
      value = {20'd0, item.hdr_size};
      if (!item.size_zero) begin
        in_region_nxt    = 1'b1;
        cur_region_nxt   = item.hdr_id;
        words_left_nxt   = item.hdr_size;
        half_pending_nxt = 1'b0;
        held_half_nxt    = 16'd0;
        fera_seen_nxt    = 1'b0;
        fera_type_nxt    = 4'd0;
        fera_module_nxt  = 4'd0;
        first_done_nxt   = 1'b0;
      end
    end else begin
      words_left_nxt = wl_dec;
      rid            = cur_region_r;
      unique case (cur_region_r) inside
        erwu_pkg::REG_RESERVED, erwu_pkg::REG_V1190: begin
        end
        erwu_pkg::REG_NIM: begin
          if (!nim_seen_r) begin
            nim_seen_nxt = 1'b1;
            ev_coin_nxt  = item.word[8];
            ev_gr_nxt    = item.word[5] || item.word[8];
            ev_las_nxt   = item.word[7] || item.word[8];
          end
          have  = 1'b1;
          kind  = erwu_pkg::KIND_NIM;
          value = {16'd0, item.word};
        end
        erwu_pkg::REG_ADC: begin
          have  = 1'b1;
          kind  = erwu_pkg::KIND_ADC;
          value = {16'd0, item.word};
        end
        erwu_pkg::REG_SCALER: begin
          pair_take = 1'b1;
          joined    = pair_ready;
          have      = joined;
          kind      = erwu_pkg::KIND_SCALER;
          value     = big_endian_r ? join_low_first : join_high_first;
        end
        erwu_pkg::REG_TIME: begin
          pair_take = !first_done_r;
          joined    = pair_take && pair_ready;
          have      = joined;
          kind      = erwu_pkg::KIND_TIME;
          value     = join_low_first;
          if (joined) begin
            first_done_nxt = 1'b1;
          end
        end
        erwu_pkg::REG_V830: begin
          pair_take = 1'b1;
          joined    = pair_ready;
          have      = joined;
          kind      = erwu_pkg::KIND_V830;
          value     = join_low_first;
        end
        erwu_pkg::REG_FERA_A, erwu_pkg::REG_FERA_B: begin
          have = 1'b1;
          if (item.fera_hdr) begin
            fera_type_nxt   = item.fera_kind;
            fera_module_nxt = item.fera_module;
            fera_seen_nxt   = 1'b1;
            kind            = erwu_pkg::KIND_FERA_HEAD;
            value           = {16'd0, item.word};
          end else begin
            kind  = erwu_pkg::KIND_FERA_DATA;
            value = {21'd0, item.fera_data};
            if (fera_seen_r) begin
              idx    = {fera_module_r, 1'b0, item.fera_chan};
              target = erwu_pkg::target_of(fera_type_r);
            end
          end
        end
        erwu_pkg::REG_CHECKSUM: begin
          if (!first_done_r) begin
            first_done_nxt = 1'b1;
            have           = 1'b1;
            kind           = erwu_pkg::KIND_CHECKSUM;
            value          = {16'd0, item.word};
          end
        end
        default: begin
          have  = 1'b1;
          kind  = erwu_pkg::KIND_UNKNOWN;
          value = {16'd0, item.word};
        end
      endcase
      // first half of a pair is parked
      if (pair_take && !half_pending_r && !closing) begin
        held_half_nxt    = item.word;
        half_pending_nxt = 1'b1;
      end else if (joined) begin
        half_pending_nxt = 1'b0;
      end
      if (closing) begin
        in_region_nxt    = 1'b0;
        half_pending_nxt = 1'b0;
      end
    end

    // silent final word still reports the event end
    if (!have) begin
      kind   = erwu_pkg::KIND_NONE;
      rid    = 4'd0;
      value  = 32'd0;
      idx    = 8'd0;
      target = erwu_pkg::TGT_NONE;
    end

    res.kind         = kind;
    res.region_id    = rid;
    res.value        = value;
    res.store_index  = idx;
    res.store_target = target;
    res.fera_kind    = fera_type_nxt;
    res.fera_module  = fera_module_nxt;
    res.gr_bit       = ev_gr_nxt;
    res.las_bit      = ev_las_nxt;
    res.coin_bit     = ev_coin_nxt;
    res.event_end    = item.last;
    res.region_cut   = item.last && in_region_nxt;

    res_valid = item_take && (have || item.last);

    // end of event: drop everything per event
    if (item.last) begin
      in_region_nxt    = 1'b0;
      cur_region_nxt   = 4'd0;
      words_left_nxt   = 12'd0;
      half_pending_nxt = 1'b0;
      held_half_nxt    = 16'd0;
      fera_seen_nxt    = 1'b0;
      fera_type_nxt    = 4'd0;
      fera_module_nxt  = 4'd0;
      nim_seen_nxt     = 1'b0;
      ev_gr_nxt        = 1'b0;
      ev_las_nxt       = 1'b0;
      ev_coin_nxt      = 1'b0;
      first_done_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
    end else if (cfg_we) begin
      big_endian_r <= cfg_big_endian_order;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_region_r    <= 1'b0;
      cur_region_r   <= 4'd0;
      words_left_r   <= 12'd0;
      fera_seen_r    <= 1'b0;
      fera_type_r    <= 4'd0;
      fera_module_r  <= 4'd0;
      held_half_r    <= 16'd0;
      half_pending_r <= 1'b0;
      nim_seen_r     <= 1'b0;
      ev_gr_r        <= 1'b0;
      ev_las_r       <= 1'b0;
      ev_coin_r      <= 1'b0;
      first_done_r   <= 1'b0;
    end else if (item_take) begin
      in_region_r    <= in_region_nxt;
      cur_region_r   <= cur_region_nxt;
      words_left_r   <= words_left_nxt;
      fera_seen_r    <= fera_seen_nxt;
      fera_type_r    <= fera_type_nxt;
      fera_module_r  <= fera_module_nxt;
      held_half_r    <= held_half_nxt;
      half_pending_r <= half_pending_nxt;
      nim_seen_r     <= nim_seen_nxt;
      ev_gr_r        <= ev_gr_nxt;
      ev_las_r       <= ev_las_nxt;
      ev_coin_r      <= ev_coin_nxt;
      first_done_r   <= first_done_nxt;
    end
  end

  a_res_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> item_take)
    else $error("result formed without a word taken");

  a_none_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.kind == erwu_pkg::KIND_NONE) |-> item.last)
    else $error("empty result not at event end");

  a_event_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.last |=> !in_region_r && !nim_seen_r && !half_pending_r)
    else $error("per-event state survived event end");

  a_pending_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    half_pending_r |-> in_region_r)
    else $error("half word held outside a region");

  a_cut_implies_region: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.region_cut |->
      item.last && (in_region_r ? !closing : !item.size_zero))
    else $error("region cut flagged with no open region");

endmodule

>>> design/event_region_word_unpacker_unit.sv
`timescale 1ns / 1ps

// words pass the input queue and region decoder; any result leaves via the result queue
// throughput: one word per cycle while the result queue has room, set by the region decoder
// input and result queues let either side stall without stopping the other
// reset: synchronous active-low rst_n clears both queues, all event state and the
// byte-order register; the block accepts words in the cycle after reset is released
module event_region_word_unpacker_unit #(
  parameter int unsigned FRONT_DEPTH = erwu_pkg::FRONT_DEPTH,
  parameter int unsigned OUT_DEPTH   = erwu_pkg::OUT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration, written while idle
  input  logic        cfg_we,
  input  logic        cfg_big_endian_order,
  // word input, queue style
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_word,
  input  logic        in_last_of_event,
  // result output, queue style
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_kind,
  output logic [3:0]  out_region_id,
  output logic [31:0] out_value,
  output logic [7:0]  out_store_index,
  output logic [2:0]  out_store_target,
  output logic [3:0]  out_fera_type,
  output logic [3:0]  out_fera_module,
  output logic        out_event_gr,
  output logic        out_event_las,
  output logic        out_event_coin,
  output logic        out_event_end,
  output logic        out_region_cut
);

  // front to back: predecoded words
  erwu_pkg::item_t item;
  logic            item_valid;
  logic            item_take;

  // back to result queue
  erwu_pkg::res_t  res;
  logic            res_valid;
  logic            res_full;
  logic [$bits(erwu_pkg::res_t)-1:0] head_bits;
  erwu_pkg::res_t  head;

  // front: takes words, splits header / fera fields, short queue
  erwu_front #(
    .DEPTH (FRONT_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .in_word          (in_word),
    .in_last_of_event (in_last_of_event),
    .full             (full),
    .item             (item),
    .item_valid       (item_valid),
    .item_take        (item_take)
  );

  // back: stateful region decoder, one word per cycle while the result queue has room
  erwu_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_big_endian_order (cfg_big_endian_order),
    .item                 (item),
    .item_valid           (item_valid),
    .item_take            (item_take),
    .res_full             (res_full),
    .res_valid            (res_valid),
    .res                  (res)
  );

  // result queue: the oldest result sits on the out_ ports while empty is low
  erwu_fifo #(
    .WIDTH ($bits(erwu_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (head_bits),
    .empty   (empty)
  );

  assign head             = erwu_pkg::res_t'(head_bits);
  assign out_kind         = head.kind;
  assign out_region_id    = head.region_id;
  assign out_value        = head.value;
  assign out_store_index  = head.store_index;
  assign out_store_target = head.store_target;
  assign out_fera_type    = head.fera_kind;
  assign out_fera_module  = head.fera_module;
  assign out_event_gr     = head.gr_bit;
  assign out_event_las    = head.las_bit;
  assign out_event_coin   = head.coin_bit;
  assign out_event_end    = head.event_end;
  assign out_region_cut   = head.region_cut;

endmodule

>>> tb/sv/event_region_word_unpacker_unit_tb.sv
`timescale 1ns / 1ps

module event_region_word_unpacker_unit_tb;

  // run length and pacing
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int RANDOM_PER_PHASE = 412;
  localparam int DRAIN_CYCLES     = 16;
  localparam int HOLD_AFTER       = 400;
  localparam int HOLD_CYCLES      = 300;

  // region ids that carry decoded bodies
  localparam logic [3:0] KNOWN_IDS [8] = '{erwu_pkg::REG_NIM, erwu_pkg::REG_ADC,
                                           erwu_pkg::REG_SCALER, erwu_pkg::REG_TIME,
                                           erwu_pkg::REG_V830, erwu_pkg::REG_FERA_A,
                                           erwu_pkg::REG_FERA_B, erwu_pkg::REG_CHECKSUM};
  // fera types that map to a store
  localparam logic [3:0] FERA_TYPES [4] = '{erwu_pkg::FTYPE_GR_ADC, erwu_pkg::FTYPE_LAS_ADC,
                                            erwu_pkg::FTYPE_GR_TDC, erwu_pkg::FTYPE_LAS_TDC};

  // directed opening, bit 16 marks the final word of an event
  localparam logic [16:0] DIRECTED [26] = '{
    17'h0_7000,                           // empty region
    17'h0_2001, 17'h0_01A0,               // nim word with coin, las and gr bits
    17'h0_3001, 17'h0_FFFF,               // adc, all-ones word
    17'h0_6003, 17'h0_AAAA, 17'h0_5555,   // scaler with an odd word count,
    17'h0_0001,                           // last pair closes on its first half
    17'h0_8003, 17'h0_1111, 17'h0_2222,   // time pair, then a surplus word
    17'h0_3333,
    17'h0_9002, 17'h0_BEEF, 17'h0_DEAD,   // v830 pair
    17'h0_D003, 17'h0_7005, 17'h0_8095,   // fera data before any header,
    17'h0_7123,                           // header type 9 module 5, data
    17'h0_F002, 17'h0_CAFE, 17'h0_0000,   // checksum, then a surplus word
    17'h0_6002, 17'h1_1234,               // event ends on a first half
    17'h1_FFFF                            // header that is also the final word
  };

  // running copy of the decoder with the queue of expected result words
  class decode_tracker;
    erwu_pkg::res_t expected_words[$];
    int          errors;
    int          checked;
    bit          order_low_first;
    bit          in_region;
    logic [3:0]  cur_region;
    logic [11:0] words_left;
    bit          fera_seen;
    logic [3:0]  ftype;
    logic [3:0]  fmodule;
    logic [15:0] held_half;
    bit          half_pending;
    bit          nim_seen;
    bit          ev_gr;
    bit          ev_las;
    bit          ev_coin;
    bit          first_done;

    function new();
      clear_event();
      order_low_first = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void clear_event();
      in_region = 1'b0;
      cur_region = '0;
      words_left = '0;
      fera_seen = 1'b0;
      ftype = '0;
      fmodule = '0;
      held_half = '0;
      half_pending = 1'b0;
      nim_seen = 1'b0;
      ev_gr = 1'b0;
      ev_las = 1'b0;
      ev_coin = 1'b0;
      first_done = 1'b0;
    endfunction

    function void set_order(bit low_first);
      order_low_first = low_first;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // returns 1 once both halves are in, or the region closes on a lone half
    function bit join_half(logic [15:0] w, bit closing, bit first_low, output logic [31:0] v);
      logic [15:0] lo;
      logic [15:0] hi;
      v = '0;
      if (!half_pending) begin
        if (!closing) begin
          held_half = w;
          half_pending = 1'b1;
          return 1'b0;
        end
        lo = first_low ? w : 16'h0000;
        hi = first_low ? 16'h0000 : w;
      end else begin
        lo = first_low ? held_half : w;
        hi = first_low ? w : held_half;
        half_pending = 1'b0;
      end
      v = {hi, lo};
      return 1'b1;
    endfunction

    function logic [2:0] store_for(logic [3:0] t);
      case (t)
        erwu_pkg::FTYPE_GR_ADC:  return erwu_pkg::TGT_GR_ADC;
        erwu_pkg::FTYPE_LAS_ADC: return erwu_pkg::TGT_LAS_ADC;
        erwu_pkg::FTYPE_GR_TDC:  return erwu_pkg::TGT_GR_TDC;
        erwu_pkg::FTYPE_LAS_TDC: return erwu_pkg::TGT_LAS_TDC;
        default:                 return erwu_pkg::TGT_NONE;
      endcase
    endfunction

    function void note_word(logic [15:0] w, logic last);
      erwu_pkg::res_t r;
      bit          have;
      bit          closing;
      logic [31:0] v;
      r = '0;
      r.store_target = erwu_pkg::TGT_NONE;
      have = 1'b0;
      if (!in_region) begin
        r.kind = erwu_pkg::KIND_HEAD;
        r.region_id = w[15:12];
        r.value = {20'h0, w[11:0]};
        have = 1'b1;
        if (w[11:0] != 12'h000) begin
          in_region = 1'b1;
          cur_region = w[15:12];
          words_left = w[11:0];
          half_pending = 1'b0;
          held_half = '0;
          fera_seen = 1'b0;
          ftype = '0;
          fmodule = '0;
          first_done = 1'b0;
        end
      end else begin
        words_left = words_left - 12'd1;
        closing = (words_left == 12'h000);
        r.region_id = cur_region;
        case (cur_region)
          erwu_pkg::REG_RESERVED, erwu_pkg::REG_V1190: ;
          erwu_pkg::REG_NIM: begin
            if (!nim_seen) begin
              nim_seen = 1'b1;
              ev_coin = w[8];
              ev_gr = w[5] | w[8];
              ev_las = w[7] | w[8];
            end
            r.kind = erwu_pkg::KIND_NIM;
            r.value = {16'h0, w};
            have = 1'b1;
          end
          erwu_pkg::REG_ADC: begin
            r.kind = erwu_pkg::KIND_ADC;
            r.value = {16'h0, w};
            have = 1'b1;
          end
          erwu_pkg::REG_SCALER: begin
            if (join_half(w, closing, order_low_first, v)) begin
              r.kind = erwu_pkg::KIND_SCALER;
              r.value = v;
              have = 1'b1;
            end
          end
          erwu_pkg::REG_TIME: begin
            if (!first_done && join_half(w, closing, 1'b1, v)) begin
              first_done = 1'b1;
              r.kind = erwu_pkg::KIND_TIME;
              r.value = v;
              have = 1'b1;
            end
          end
          erwu_pkg::REG_V830: begin
            if (join_half(w, closing, 1'b1, v)) begin
              r.kind = erwu_pkg::KIND_V830;
              r.value = v;
              have = 1'b1;
            end
          end
          erwu_pkg::REG_FERA_A, erwu_pkg::REG_FERA_B: begin
            if (w[15]) begin
              ftype = w[7:4];
              fmodule = w[3:0];
              fera_seen = 1'b1;
              r.kind = erwu_pkg::KIND_FERA_HEAD;
              r.value = {16'h0, w};
            end else begin
              r.kind = erwu_pkg::KIND_FERA_DATA;
              r.value = {21'h0, w[10:0]};
              if (fera_seen) begin
                r.store_index = {fmodule, 1'b0, w[14:12]};
                r.store_target = store_for(ftype);
              end
            end
            have = 1'b1;
          end
          erwu_pkg::REG_CHECKSUM: begin
            if (!first_done) begin
              first_done = 1'b1;
              r.kind = erwu_pkg::KIND_CHECKSUM;
              r.value = {16'h0, w};
              have = 1'b1;
            end
          end
          default: begin
            r.kind = erwu_pkg::KIND_UNKNOWN;
            r.value = {16'h0, w};
            have = 1'b1;
          end
        endcase
        if (closing) begin
          in_region = 1'b0;
          half_pending = 1'b0;
        end
      end

      if (!have && !last) return;
      if (!have) begin
        r = '0;
        r.store_target = erwu_pkg::TGT_NONE;
      end
      r.fera_kind = ftype;
      r.fera_module = fmodule;
      r.gr_bit = ev_gr;
      r.las_bit = ev_las;
      r.coin_bit = ev_coin;
      r.event_end = last;
      r.region_cut = last & in_region;
      expected_words.insert(expected_words.size(), r);
      if (last) clear_event();
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_word(erwu_pkg::res_t seen);
      erwu_pkg::res_t want;
      checked++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: kind %0d value %0h", seen.kind, seen.value);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      field_check("kind", 32'(want.kind), 32'(seen.kind));
      field_check("region_id", 32'(want.region_id), 32'(seen.region_id));
      field_check("value", want.value, seen.value);
      field_check("store_index", 32'(want.store_index), 32'(seen.store_index));
      field_check("store_target", 32'(want.store_target), 32'(seen.store_target));
      field_check("out_fera_type", 32'(want.fera_kind), 32'(seen.fera_kind));
      field_check("fera_module", 32'(want.fera_module), 32'(seen.fera_module));
      field_check("out_event_gr", 32'(want.gr_bit), 32'(seen.gr_bit));
      field_check("out_event_las", 32'(want.las_bit), 32'(seen.las_bit));
      field_check("out_event_coin", 32'(want.coin_bit), 32'(seen.coin_bit));
      field_check("event_end", 32'(want.event_end), 32'(seen.event_end));
      field_check("region_cut", 32'(want.region_cut), 32'(seen.region_cut));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_big_endian_order;
  logic        push;
  logic        full;
  logic [15:0] in_word;
  logic        in_last_of_event;
  logic        empty;
  logic        pop;
  logic [3:0]  out_kind;
  logic [3:0]  out_region_id;
  logic [31:0] out_value;
  logic [7:0]  out_store_index;
  logic [2:0]  out_store_target;
  logic [3:0]  out_fera_type;
  logic [3:0]  out_fera_module;
  logic        out_event_gr;
  logic        out_event_las;
  logic        out_event_coin;
  logic        out_event_end;
  logic        out_region_cut;

  decode_tracker track;
  logic [15:0]   event_words[$];
  int            words_sent = 0;
  int            cycle_count = 0;
  bit            steady = 1'b0;

  event_region_word_unpacker_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_big_endian_order (cfg_big_endian_order),
    .push                 (push),
    .full                 (full),
    .in_word              (in_word),
    .in_last_of_event     (in_last_of_event),
    .empty                (empty),
    .pop                  (pop),
    .out_kind             (out_kind),
    .out_region_id        (out_region_id),
    .out_value            (out_value),
    .out_store_index      (out_store_index),
    .out_store_target     (out_store_target),
    .out_fera_type        (out_fera_type),
    .out_fera_module      (out_fera_module),
    .out_event_gr         (out_event_gr),
    .out_event_las        (out_event_las),
    .out_event_coin       (out_event_coin),
    .out_event_end        (out_event_end),
    .out_region_cut       (out_region_cut)
  );

  always #4 clk = ~clk;

  // hard stop in case the handshake hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // alternate stretches with and without idle gaps
  initial begin
    forever begin
      repeat ($urandom_range(200, 600)) @(posedge clk);
      steady = 1'b1;
      repeat ($urandom_range(50, 150)) @(posedge clk);
      steady = 1'b0;
    end
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // fera body word: header with a likely mapped type, or a data word
  function automatic logic [15:0] fera_word(bit first);
    logic [3:0] t;
    if ($urandom_range(0, 99) < (first ? 80 : 25)) begin
      t = ($urandom_range(0, 99) < 70) ? FERA_TYPES[2'($urandom_range(0, 3))] : 4'($urandom);
      return {1'b1, 7'($urandom), t, 4'($urandom)};
    end
    return {1'b0, 15'($urandom)};
  endfunction

  // one region: header plus a body of mostly small size
  function automatic void add_region();
    logic [3:0] id;
    int         size;
    int         r;
    id = ($urandom_range(0, 99) < 82) ? KNOWN_IDS[3'($urandom_range(0, 7))] : 4'($urandom);
    r = $urandom_range(0, 99);
    if (r < 8) size = 0;
    else if (r < 85) size = $urandom_range(1, 8);
    else if (r < 97) size = $urandom_range(9, 40);
    else size = $urandom_range(41, 160);
    event_words.insert(event_words.size(), {id, 12'(size)});
    for (int i = 0; i < size; i++) begin
      if (id == erwu_pkg::REG_FERA_A || id == erwu_pkg::REG_FERA_B)
        event_words.insert(event_words.size(), fera_word(i == 0));
      else event_words.insert(event_words.size(), 16'($urandom));
    end
  endfunction

  // offer one word and wait until the block takes it
  task automatic send_word(logic [15:0] w, logic last);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_word <= w;
    in_last_of_event <= last;
    // full is stable by the falling edge, so it tells what the next edge does
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    track.note_word(w, last);
    words_sent++;
  endtask

  // one event: well formed most of the time, else cut short or plain noise
  task automatic send_event();
    int r;
    int cut;
    event_words.delete();
    r = $urandom_range(0, 99);
    if (r < 78) begin
      repeat ($urandom_range(1, 5)) add_region();
    end else if (r < 90) begin
      // event ends somewhere inside its regions
      repeat ($urandom_range(1, 4)) add_region();
      cut = $urandom_range(0, event_words.size() - 1);
      while (event_words.size() > cut + 1) void'(event_words.pop_back());
    end else if (r < 95) begin
      // header of any size, then the event stops early
      event_words.insert(event_words.size(), 16'($urandom));
      repeat ($urandom_range(0, 3)) event_words.insert(event_words.size(), 16'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) event_words.insert(event_words.size(), 16'($urandom));
    end
    foreach (event_words[i]) send_word(event_words[i], i == event_words.size() - 1);
  endtask

  // byte order register, only written with nothing in flight
  task automatic write_order(bit low_first);
    cfg_we <= 1'b1;
    cfg_big_endian_order <= low_first;
    @(posedge clk);
    cfg_we <= 1'b0;
    track.set_order(low_first);
  endtask

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    int  stall_left;
    int  gap;
    bit  held_long;
    pop = 1'b0;
    stall_left = 0;
    held_long = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_long && track != null && track.checked >= HOLD_AFTER) begin
        held_long = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        gap = pick_gap();
        pop <= (gap == 0);
        stall_left = gap;
      end
    end
  end

  // compare each word the block hands over before the edge that takes it
  always @(negedge clk) begin : result_check
    erwu_pkg::res_t seen;
    if (rst_n && pop && !empty) begin
      seen.kind = out_kind;
      seen.region_id = out_region_id;
      seen.value = out_value;
      seen.store_index = out_store_index;
      seen.store_target = out_store_target;
      seen.fera_kind = out_fera_type;
      seen.fera_module = out_fera_module;
      seen.gr_bit = out_event_gr;
      seen.las_bit = out_event_las;
      seen.coin_bit = out_event_coin;
      seen.event_end = out_event_end;
      seen.region_cut = out_region_cut;
      track.check_word(seen);
    end
  end

  initial begin
    int target;
    track = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_big_endian_order = 1'b0;
    push = 1'b0;
    in_word = '0;
    in_last_of_event = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // four phases, byte order alternating between its two settings
    for (int phase = 0; phase < 4; phase++) begin
      write_order(phase[0]);
      if (phase == 0) begin
        foreach (DIRECTED[i]) send_word(DIRECTED[i][15:0], DIRECTED[i][16]);
      end
      target = words_sent + RANDOM_PER_PHASE;
      while (words_sent < target) send_event();
      push <= 1'b0;
      // every phase ends on an event end, so the last word always gives a result
      while (track.pending() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (track.errors == 0 && track.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
design/erwu_pkg.sv
design/erwu_fifo.sv
design/erwu_front.sv
design/erwu_back.sv
design/event_region_word_unpacker_unit.sv
tb/sv/event_region_word_unpacker_unit_tb.sv
